/* rtl/shuffled_lehmer_uniform_generator_macros.svh */
// assertion helpers shared by the rtl
`ifndef SHUFFLED_LEHMER_UNIFORM_GENERATOR_MACROS_SVH
`define SHUFFLED_LEHMER_UNIFORM_GENERATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SLUG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slug assertion failed");

// next-cycle implication, disabled while in reset
`define SLUG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slug assertion failed");

`endif

/* rtl/slug_pkg.sv */
`default_nettype none

package slug_pkg;

  // shuffle table geometry, table size must be a power of two
  localparam int unsigned TABLE_SIZE   = 32;
  localparam int unsigned WARMUP_STEPS = 8;
  localparam int unsigned IDX_W        = $clog2(TABLE_SIZE);
  localparam int unsigned START_STEPS  = TABLE_SIZE + WARMUP_STEPS;
  localparam int unsigned CNT_W        = $clog2(START_STEPS + 1);

  localparam int unsigned VAL_W  = 31;
  localparam int unsigned MUL_W  = 15;
  localparam int unsigned PROD_W = VAL_W + MUL_W;

  localparam logic [VAL_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;
  localparam logic [MUL_W-1:0] LEHMER_MUL = 15'd16807;
  localparam logic [VAL_W-1:0] SAMPLE_MAX = 31'd2147483389;
  localparam logic [VAL_W-1:0] SEED_ONE   = 31'd1;

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  // slot = last output / 2^(31 - IDX_W), i.e. its top bits
  localparam int unsigned SLOT_SHIFT = VAL_W - IDX_W;

endpackage

`default_nettype wire

/* rtl/shuffled_lehmer_uniform_generator.sv */
// a plain draw passes the multiply and reduce states, its item is registered at the output
// as in_ready returns; a reseed, or the first draw after reset, first runs every start step
// one request at a time, held in reduce while the output is full; the shared multiply/reduce
// unit registers the 31x15 product, then folds it mod 2^31-1
// reset: synchronous active-low, seed 1, unseeded, no output pending, table not cleared
`default_nettype none

module shuffled_lehmer_uniform_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [30:0] in_seed_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [30:0]      out_sample,
  output logic [30:0]      out_next_seed
);

  `include "shuffled_lehmer_uniform_generator_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM_MUL,
    ST_WARM_RED,
    ST_DRAW_MUL,
    ST_DRAW_RED
  } state_t;

  state_t                                    state_r, state_nxt;
  logic [slug_pkg::VAL_W-1:0]                seed_r, seed_nxt;
  logic [slug_pkg::VAL_W-1:0]                last_out_r, last_out_nxt;
  logic [slug_pkg::CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [slug_pkg::PROD_W-1:0]               prod_r, prod_nxt;
  logic                                      out_valid_r, out_valid_nxt;
  logic [slug_pkg::VAL_W-1:0]                out_sample_r, out_sample_nxt;
  logic [slug_pkg::VAL_W-1:0]                out_seed_r, out_seed_nxt;

  // shuffle table, one write and one registered read port
  logic [slug_pkg::VAL_W-1:0] table_mem [slug_pkg::TABLE_SIZE];
  logic [slug_pkg::VAL_W-1:0] rd_data_r;
  logic                       rd_en;
  logic [slug_pkg::IDX_W-1:0] rd_addr;
  logic                       wr_en;
  logic [slug_pkg::IDX_W-1:0] wr_addr;
  logic [slug_pkg::VAL_W-1:0] wr_data;

  logic                       in_acc;
  logic                       out_free;
  logic [slug_pkg::VAL_W-1:0] start_seed;
  logic [slug_pkg::VAL_W:0]   fold_sum;
  logic [slug_pkg::VAL_W-1:0] red;
  logic [slug_pkg::IDX_W-1:0] slot;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_next_seed = out_seed_r;

  // output register frees up this cycle if its item is taken
  assign out_free = !out_valid_r || out_ready;

  // zero and the modulus itself both start from seed one
  always_comb begin
    if (in_kind == slug_pkg::KIND_RESEED && in_seed_value != '0 &&
        in_seed_value != slug_pkg::LEHMER_MOD) begin
      start_seed = in_seed_value;
    end else begin
      start_seed = slug_pkg::SEED_ONE;
    end
  end

  // shared unit, fold step: hi*2^31 + lo == hi + lo mod 2^31-1, one correction
  assign fold_sum = (slug_pkg::VAL_W+1)'(prod_r[slug_pkg::PROD_W-1:slug_pkg::VAL_W]) +
                    (slug_pkg::VAL_W+1)'(prod_r[slug_pkg::VAL_W-1:0]);
  always_comb begin
    if (fold_sum >= (slug_pkg::VAL_W+1)'(slug_pkg::LEHMER_MOD)) begin
      red = slug_pkg::VAL_W'(fold_sum - (slug_pkg::VAL_W+1)'(slug_pkg::LEHMER_MOD));
    end else begin
      red = fold_sum[slug_pkg::VAL_W-1:0];
    end
  end

  // previous output's top bits pick the slot
  assign slot = last_out_r[slug_pkg::VAL_W-1:slug_pkg::SLOT_SHIFT];

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    seed_nxt       = seed_r;
    last_out_nxt   = last_out_r;
    cnt_nxt        = cnt_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_sample_nxt = out_sample_r;
    out_seed_nxt   = out_seed_r;
    rd_en          = 1'b0;
    rd_addr        = slot;
    wr_en          = 1'b0;
    wr_addr        = slot;
    wr_data        = red;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == slug_pkg::KIND_RESEED || last_out_r == '0) begin
            seed_nxt  = start_seed;
            cnt_nxt   = slug_pkg::CNT_W'(slug_pkg::START_STEPS);
            state_nxt = ST_WARM_MUL;
          end else begin
            state_nxt = ST_DRAW_MUL;
          end
        end
      end
      ST_WARM_MUL: begin
        prod_nxt  = slug_pkg::PROD_W'(seed_r) * slug_pkg::PROD_W'(slug_pkg::LEHMER_MUL);
        state_nxt = ST_WARM_RED;
      end
      ST_WARM_RED: begin
        seed_nxt = red;
        cnt_nxt  = cnt_r - 1'b1;
        // last table-size steps fill from the top slot down
        if (cnt_r <= slug_pkg::CNT_W'(slug_pkg::TABLE_SIZE)) begin
          wr_en   = 1'b1;
          wr_addr = slug_pkg::IDX_W'(cnt_r - 1'b1);
        end
        if (cnt_r == slug_pkg::CNT_W'(1)) begin
          // slot 0 holds this word and becomes the previous output
          last_out_nxt = red;
          state_nxt    = ST_DRAW_MUL;
        end else begin
          state_nxt = ST_WARM_MUL;
        end
      end
      ST_DRAW_MUL: begin
        prod_nxt  = slug_pkg::PROD_W'(seed_r) * slug_pkg::PROD_W'(slug_pkg::LEHMER_MUL);
        rd_en     = 1'b1;
        state_nxt = ST_DRAW_RED;
      end
      ST_DRAW_RED: begin
        // hold here while the previous item still waits at the output
        if (out_free) begin
          seed_nxt     = red;
          last_out_nxt = rd_data_r;
          wr_en        = 1'b1;
          out_valid_nxt = 1'b1;
          out_seed_nxt  = red;
          if (rd_data_r > slug_pkg::SAMPLE_MAX) begin
            out_sample_nxt = slug_pkg::SAMPLE_MAX;
          end else begin
            out_sample_nxt = rd_data_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= slug_pkg::SEED_ONE;
      last_out_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      last_out_r  <= last_out_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    out_sample_r <= out_sample_nxt;
    out_seed_r   <= out_seed_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= table_mem[rd_addr];
    end
  end

  `SLUG_ASSERT_NEXT(a_accept_busy, in_acc, state_r != ST_IDLE)
  `SLUG_ASSERT_NOW(a_warm_count, state_r == ST_WARM_MUL || state_r == ST_WARM_RED, cnt_r != '0)
  `SLUG_ASSERT_NOW(a_draw_seeded, state_r == ST_DRAW_MUL, last_out_r != '0)
  `SLUG_ASSERT_NOW(a_seed_range, out_valid_r,
                   out_seed_r != '0 && out_seed_r != slug_pkg::LEHMER_MOD)

endmodule

`default_nettype wire

/* sim/tb_shuffled_lehmer_uniform_generator.sv */
`timescale 1ns / 100ps

module tb_shuffled_lehmer_uniform_generator;
  import slug_pkg::*;

  typedef logic [VAL_W-1:0] word_t;

  // one request to the generator: its kind and seed value
  typedef struct packed {
    logic  kind;
    word_t seed_value;
  } draw_req_t;

  typedef struct packed {
    word_t sample;
    word_t next_seed;
  } draw_res_t;

  localparam longint unsigned MODULUS  = LEHMER_MOD;
  // slot divisor, works out to 2^26 for a 32-entry table
  localparam longint unsigned SLOT_DIV = 1 + (MODULUS - 1) / TABLE_SIZE;

  localparam int unsigned RANDOM_ITEMS = 1380;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  // worst run is roughly 1400 items, every one a start, plus gaps on both sides
  localparam real         TIMEOUT_NS   = 8_000_000.0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = KIND_DRAW;
  word_t       in_seed_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  word_t       out_sample;
  word_t       out_next_seed;

  shuffled_lehmer_uniform_generator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_seed_value (in_seed_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample    (out_sample),
    .out_next_seed (out_next_seed)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // generator prediction: own copy of seed, shuffle slots and previous output
  // ---------------------------------------------------------------------------

  word_t     gen_seed = SEED_ONE;
  word_t     prev_out = '0;          // zero means never started
  word_t     shuffle [TABLE_SIZE];
  draw_res_t expected_draws [$];

  // a * b mod (2^31 - 1), both operands below 2^31 so the product fits
  function automatic word_t mulmod(word_t a, word_t b);
    longint unsigned p;
    p = 64'(a);
    p = (p * 64'(b)) % MODULUS;
    return word_t'(p);
  endfunction

  function automatic word_t modpow(word_t b, longint unsigned e);
    word_t r;
    word_t x;
    r = SEED_ONE;
    x = b;
    while (e != 0) begin
      if ((e & 1) != 0) r = mulmod(r, x);
      x = mulmod(x, x);
      e = e >> 1;
    end
    return r;
  endfunction

  // warm-up then fill the slots from the top one down, slot 0 seeds the shuffle
  function automatic void restart_stream(word_t seed);
    word_t s;
    s = seed;
    // zero and the modulus itself are both congruent to zero
    if (s == '0 || s == LEHMER_MOD) s = SEED_ONE;
    for (int left = START_STEPS; left >= 1; left--) begin
      s = mulmod(s, word_t'(LEHMER_MUL));
      if (left <= TABLE_SIZE) shuffle[left-1] = s;
    end
    gen_seed = s;
    prev_out = shuffle[0];
  endfunction

  function automatic void predict_draw(logic kind, word_t seed_value);
    int unsigned slot;
    draw_res_t   res;
    if (kind == KIND_RESEED) restart_stream(seed_value);
    else if (prev_out == '0) restart_stream(SEED_ONE);   // unseeded draw starts from 1
    gen_seed = mulmod(gen_seed, word_t'(LEHMER_MUL));
    slot = 32'(64'(prev_out) / SLOT_DIV);
    if (slot >= TABLE_SIZE) slot = TABLE_SIZE - 1;
    prev_out = shuffle[slot];
    shuffle[slot] = gen_seed;
    // clamp keeps the fraction strictly below one
    res.sample    = (prev_out > SAMPLE_MAX) ? SAMPLE_MAX : prev_out;
    res.next_seed = gen_seed;
    expected_draws.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  draw_req_t draw_requests [$];

  function automatic void queue_item(logic kind, word_t seed_value);
    draw_req_t item;
    item.kind       = kind;
    item.seed_value = seed_value;
    draw_requests.push_back(item);
  endfunction

  // search for reseed values whose first draw lands above the clamp:
  // after a start slot k holds seed * 16807^(START_STEPS-k), and slot 0 picks
  // slot k when its top bits equal k, so work backward from the wanted word
  function automatic void queue_clamp_starts(int unsigned want);
    word_t           inv_mul;
    word_t           word;
    word_t           head;
    int unsigned     found;
    longint unsigned v;
    found   = 0;
    inv_mul = modpow(word_t'(LEHMER_MUL), MODULUS - 2);
    for (v = MODULUS - 1; v > SAMPLE_MAX && found < want; v--) begin
      word = word_t'(v);
      for (int k = 0; k < TABLE_SIZE && found < want; k++) begin
        head = mulmod(word, modpow(word_t'(LEHMER_MUL), 64'(k)));
        if (head / SLOT_DIV == k) begin
          queue_item(KIND_RESEED, mulmod(word, modpow(inv_mul, 64'(START_STEPS - k))));
          found++;
        end
      end
    end
  endfunction

  // mostly back-to-back or short gaps, a few long ones, now and then a burst
  function automatic int unsigned pick_gap(inout int unsigned burst);
    int unsigned r;
    if (burst != 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued items at the falling edge, holds until accepted
  // ---------------------------------------------------------------------------

  int unsigned items_offered  = 0;
  int unsigned items_accepted = 0;
  int unsigned send_gap       = 0;
  int unsigned send_burst     = 0;

  always @(negedge clk) begin
    draw_req_t item;
    logic      next_valid;
    next_valid = in_valid;
    // only move on once the item on the port has been taken
    if (rst_n && items_offered == items_accepted) begin
      if (send_gap != 0) begin
        send_gap--;
        next_valid = 1'b0;
      end else if (draw_requests.size() != 0) begin
        item = draw_requests.pop_front();
        in_kind       <= item.kind;
        in_seed_value <= item.seed_value;
        items_offered++;
        next_valid = 1'b1;
        send_gap   = pick_gap(send_burst);
      end else begin
        next_valid = 1'b0;
      end
    end
    in_valid <= next_valid;
  end

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure, plus one long hold to fill the block
  // ---------------------------------------------------------------------------

  int unsigned recv_gap       = 0;
  int unsigned recv_burst     = 0;
  int unsigned hold_left      = 0;
  bit          long_hold_done = 1'b0;
  int unsigned draws_checked  = 0;

  always @(negedge clk) begin
    logic next_ready;
    if (!rst_n) begin
      next_ready = 1'b0;
    end else if (!long_hold_done && draws_checked >= HOLD_AFTER) begin
      // sender keeps going, so in_ready must drop while this lasts
      hold_left      = LONG_HOLD;
      long_hold_done = 1'b1;
      next_ready     = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
      recv_gap   = pick_gap(recv_burst);
    end
    out_ready <= next_ready;
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on input handshake, check on output handshake
  // ---------------------------------------------------------------------------

  int unsigned error_count = 0;

  always @(posedge clk) begin
    draw_res_t want;
    if (rst_n && in_valid && in_ready) begin
      predict_draw(in_kind, in_seed_value);
      items_accepted++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_draws.size() == 0) begin
        $error("unexpected result: sample %0d next_seed %0d", out_sample, out_next_seed);
        error_count++;
      end else begin
        want = expected_draws.pop_front();
        if (out_sample !== want.sample) begin
          $error("sample mismatch: expected %0d, got %0d", want.sample, out_sample);
          error_count++;
        end
        if (out_next_seed !== want.next_seed) begin
          $error("next_seed mismatch: expected %0d, got %0d", want.next_seed, out_next_seed);
          error_count++;
        end
        draws_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned r;
    word_t       s;

    // directed: first draw with nothing seeded, seed_value ignored on a draw
    queue_item(KIND_DRAW, LEHMER_MOD);
    queue_item(KIND_DRAW, word_t'($urandom));
    queue_item(KIND_DRAW, '0);
    // zero seed, seed equal to the modulus, smallest and largest real seeds
    queue_item(KIND_RESEED, '0);
    queue_item(KIND_DRAW, '0);
    queue_item(KIND_RESEED, LEHMER_MOD);
    queue_item(KIND_DRAW, LEHMER_MOD);
    queue_item(KIND_RESEED, SEED_ONE);
    queue_item(KIND_DRAW, '0);
    queue_item(KIND_RESEED, LEHMER_MOD - 1);
    queue_item(KIND_DRAW, '0);
    // alternating bit patterns, back-to-back reseeds
    queue_item(KIND_RESEED, 31'h2AAA_AAAA);
    queue_item(KIND_RESEED, 31'h5555_5555);
    queue_item(KIND_DRAW, 31'h2AAA_AAAA);
    queue_item(KIND_DRAW, 31'h5555_5555);
    // starts whose first sample has to be clamped
    queue_clamp_starts(2);
    queue_item(KIND_DRAW, '0);

    // random: mostly draws, some reseeds with random or extreme seeds
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        case ($urandom_range(0, 9))
          0:       s = '0;
          1:       s = LEHMER_MOD;
          2:       s = SEED_ONE;
          3:       s = LEHMER_MOD - 1;
          default: s = word_t'($urandom);
        endcase
        queue_item(KIND_RESEED, s);
      end else begin
        queue_item(KIND_DRAW, word_t'($urandom));
      end
    end

    // hold reset, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for every item to go in and every draw to come back
    do @(negedge clk);
    while (draw_requests.size() != 0 || items_offered != items_accepted ||
           expected_draws.size() != 0);
    // catch any stray result after the last one
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $error("timeout with %0d draws still expected", expected_draws.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/slug_pkg.sv
rtl/shuffled_lehmer_uniform_generator.sv
sim/tb_shuffled_lehmer_uniform_generator.sv
